// File: hdl/irbft_pkg.sv
// shared constants and types for the infrared byte frame transceiver
package irbft_pkg;

   localparam int FRAME_STEPS = 18;
   localparam int POS_W = 5;
   localparam int BYTE_W = 8;
   localparam int WORD_W = 2 * BYTE_W;

   localparam logic [POS_W-1:0] POS_START = '0;
   localparam logic [POS_W-1:0] POS_STOP = POS_W'(FRAME_STEPS - 1);
   localparam logic [POS_W-1:0] POS_IDLE = POS_W'(FRAME_STEPS);
   localparam logic [POS_W-1:0] POS_INV_FIRST = POS_W'(1);
   localparam logic [POS_W-1:0] POS_INV_LAST = POS_W'(BYTE_W);
   localparam logic [POS_W-1:0] POS_DATA_LAST = POS_W'(WORD_W);

   localparam logic [BYTE_W-1:0] BIT_PERIOD_RESET = 8'd76;
   localparam logic [BYTE_W-1:0] BYTE_ALL_ONES = 8'hFF;

   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_SEND = 1'b1;

   // per-item control from the tick divider to both units
   typedef struct packed {
      logic step;
      logic send;
   } ctl_type;

   typedef struct packed {
      logic carrier_on;
      logic busy;
   } tx_status_type;

   typedef struct packed {
      logic accepted;
      logic [BYTE_W-1:0] held_byte;
   } rx_status_type;

endpackage

// File: hdl/irbft_tx.sv
// transmit frame sequencer: gates the carrier through the 18 bit steps
module irbft_tx
   import irbft_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  ctl_type ctl,
   input  logic [BYTE_W-1:0] tx_value,
   output tx_status_type status
);

   logic [WORD_W-1:0] word_ff, word_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic carrier_ff, carrier_in;
   logic [POS_W-1:0] pos_m1;

   assign pos_m1 = pos_ff - POS_W'(1);

   always_comb begin
      word_in = word_ff;
      pos_in = pos_ff;
      carrier_in = carrier_ff;
      if (ctl.send) begin
         word_in = {tx_value, ~tx_value};
         pos_in = POS_START;
      end else if (ctl.step) begin
         if (pos_ff < POS_IDLE && word_ff != '0) begin
            if (pos_ff == POS_START || pos_ff == POS_STOP) begin
               carrier_in = 1'b1;
            end else begin
               carrier_in = word_ff[pos_m1[3:0]];
            end
            pos_in = pos_ff + POS_W'(1);
         end else if (pos_ff >= POS_IDLE) begin
            carrier_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
         pos_ff <= POS_IDLE;
         carrier_ff <= 1'b0;
      end else begin
         word_ff <= word_in;
         pos_ff <= pos_in;
         carrier_ff <= carrier_in;
      end
   end

   // status reflects the state after this item
   assign status.carrier_on = carrier_in;
   assign status.busy = (pos_in < POS_IDLE);

endmodule

// File: hdl/irbft_rx.sv
// receive frame sequencer: shifts in both bytes and checks the stop mark
module irbft_rx
   import irbft_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  ctl_type ctl,
   input  logic mark,
   output rx_status_type status
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [BYTE_W-1:0] inv_ff, inv_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic [BYTE_W-1:0] held_ff, held_in;
   logic accepted;
   logic [POS_W-1:0] pos_m1;

   // inverted bits sit at positions 1..8, data at 9..16: low 3 bits of pos-1 index both
   assign pos_m1 = pos_ff - POS_W'(1);

   always_comb begin
      pos_in = pos_ff;
      inv_in = inv_ff;
      data_in = data_ff;
      held_in = held_ff;
      accepted = 1'b0;
      if (ctl.step) begin
         if (pos_ff == POS_START) begin
            if (mark) begin
               pos_in = POS_INV_FIRST;
               inv_in = '0;
               data_in = '0;
            end
         end else if (pos_ff inside {[POS_INV_FIRST:POS_INV_LAST]}) begin
            inv_in[pos_m1[2:0]] = inv_ff[pos_m1[2:0]] | mark;
            pos_in = pos_ff + POS_W'(1);
         end else if (pos_ff <= POS_DATA_LAST) begin
            data_in[pos_m1[2:0]] = data_ff[pos_m1[2:0]] | mark;
            pos_in = pos_ff + POS_W'(1);
         end else begin
            pos_in = POS_START;
            if (pos_ff == POS_STOP && mark && data_ff == ~inv_ff &&
                data_ff != BYTE_ALL_ONES) begin
               held_in = data_ff;
               accepted = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_START;
         inv_ff <= '0;
         data_ff <= '0;
         held_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         inv_ff <= inv_in;
         data_ff <= data_in;
         held_ff <= held_in;
      end
   end

   assign status.accepted = accepted;
   assign status.held_byte = held_in;

endmodule

// File: hdl/ir_byte_frame_transceiver_top.sv
// top level: tick divider, transmit and receive units, result register
// The divider and both frame units update their state from each accepted item
// and the result is captured in a single output register,
// so an item is taken every cycle unless that register is full and stalled.
// A bit step occurs on a tick item when the tick count equals bit_period
// (the first one bit_period+1 ticks after reset); a send item restarts the
// transmit frame without counting a tick. csr writes are registered before they take effect.
module ir_byte_frame_transceiver_top
   import irbft_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic [BYTE_W-1:0] csr_wr_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_action,
   input  logic req_rx_line_low,
   input  logic [BYTE_W-1:0] req_tx_value,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_carrier_enable,
   output logic rsp_rx_valid,
   output logic [BYTE_W-1:0] rsp_rx_byte,
   output logic rsp_tx_busy
);

   logic [BYTE_W-1:0] period_ff, period_in;
   logic [BYTE_W-1:0] tick_ff, tick_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic carrier_ff, rx_valid_ff, tx_busy_ff;
   logic [BYTE_W-1:0] rx_byte_ff;
   logic accept;
   ctl_type ctl;
   tx_status_type tx_status;
   rx_status_type rx_status;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept = req_valid & ~req_stall;

   assign ctl.send = accept && req_action == ACTION_SEND;
   assign ctl.step = accept && req_action == ACTION_TICK && tick_ff == period_ff;

   always_comb begin
      tick_in = tick_ff;
      if (accept && req_action == ACTION_TICK) begin
         tick_in = ctl.step ? BYTE_W'(1) : tick_ff + BYTE_W'(1);
      end
   end

   assign period_in = csr_wr_en ? csr_wr_data : period_ff;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   irbft_tx u_tx (
      .clock(clock),
      .reset(reset),
      .ctl(ctl),
      .tx_value(req_tx_value),
      .status(tx_status)
   );

   irbft_rx u_rx (
      .clock(clock),
      .reset(reset),
      .ctl(ctl),
      .mark(req_rx_line_low),
      .status(rx_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= BIT_PERIOD_RESET;
         tick_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff <= period_in;
         tick_ff <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         carrier_ff <= tx_status.carrier_on;
         rx_valid_ff <= rx_status.accepted;
         rx_byte_ff <= rx_status.held_byte;
         tx_busy_ff <= tx_status.busy;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_carrier_enable = carrier_ff;
   assign rsp_rx_valid = rx_valid_ff;
   assign rsp_rx_byte = rx_byte_ff;
   assign rsp_tx_busy = tx_busy_ff;

`ifndef SYNTH
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("input stalled with empty result register");

   a_rx_byte_checked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rx_valid_ff) |-> (rx_byte_ff != BYTE_ALL_ONES))
      else $error("received byte of all ones flagged valid");

   a_send_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.send |=> tx_busy_ff)
      else $error("send item did not report transmitter busy");
`endif

endmodule

// File: tb/sv/ir_byte_frame_transceiver_top_tb.sv
// self-checking testbench for the infrared byte frame transceiver top level
`timescale 1ns / 1ps

module ir_byte_frame_transceiver_top_tb;
   import irbft_pkg::*;

   localparam int RUN_LIMIT = 200000;
   localparam int LONG_HOLD = 60;
   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      logic carrier_enable;
      logic rx_valid;
      logic [BYTE_W-1:0] rx_byte;
      logic tx_busy;
   } ir_result_type;

   typedef enum logic {ROW_ITEM, ROW_PERIOD} row_kind_type;

   typedef enum int {
      SHAPE_GOOD, SHAPE_ALL_ONES, SHAPE_BAD_CHECK, SHAPE_NO_STOP, SHAPE_NOISE
   } frame_shape_type;

   typedef struct packed {
      row_kind_type kind;
      logic action;
      logic line_low;
      logic [BYTE_W-1:0] value;
      logic typed;
      ir_result_type want;
   } drill_row_type;

   localparam ir_result_type RES_IDLE = '0;
   localparam ir_result_type RES_BUSY = '{1'b0, 1'b0, 8'h00, 1'b1};
   localparam int DRILL_LEN = 24;

   // after reset, sends at the byte extremes, then a frame of 0x3c at one tick per step
   localparam drill_row_type DRILL_ROWS [DRILL_LEN] = '{
      '{ROW_ITEM, ACTION_TICK, 1'b0, 8'h00, 1'b1, RES_IDLE},
      '{ROW_ITEM, ACTION_SEND, 1'b0, 8'h00, 1'b1, RES_BUSY},
      '{ROW_ITEM, ACTION_SEND, 1'b1, 8'hFF, 1'b1, RES_BUSY},
      '{ROW_ITEM, ACTION_SEND, 1'b0, 8'h80, 1'b1, RES_BUSY},
      '{ROW_PERIOD, ACTION_TICK, 1'b0, 8'd1, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_SEND, 1'b1, 8'h01, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_TICK, 1'b1, 8'hFF, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_TICK, 1'b1, 8'h00, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_TICK, 1'b1, 8'h00, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_TICK, 1'b0, 8'h00, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_TICK, 1'b0, 8'h00, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_TICK, 1'b0, 8'h00, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_TICK, 1'b0, 8'h00, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_TICK, 1'b1, 8'h00, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_TICK, 1'b1, 8'h00, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_TICK, 1'b0, 8'h00, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_TICK, 1'b0, 8'h00, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_TICK, 1'b1, 8'h00, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_TICK, 1'b1, 8'h00, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_TICK, 1'b1, 8'h00, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_TICK, 1'b1, 8'h00, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_TICK, 1'b0, 8'h00, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_TICK, 1'b0, 8'h00, 1'b0, RES_IDLE},
      '{ROW_ITEM, ACTION_TICK, 1'b1, 8'h00, 1'b0, RES_IDLE}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [BYTE_W-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = ACTION_TICK;
   logic req_rx_line_low = 1'b0;
   logic [BYTE_W-1:0] req_tx_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_carrier_enable;
   logic rsp_rx_valid;
   logic [BYTE_W-1:0] rsp_rx_byte;
   logic rsp_tx_busy;

   ir_byte_frame_transceiver_top i_dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_rx_line_low(req_rx_line_low),
      .req_tx_value(req_tx_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_carrier_enable(rsp_carrier_enable),
      .rsp_rx_valid(rsp_rx_valid),
      .rsp_rx_byte(rsp_rx_byte),
      .rsp_tx_busy(rsp_tx_busy)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // transceiver state as the block should hold it
   logic [BYTE_W-1:0] cur_bit_period = BIT_PERIOD_RESET;
   logic [BYTE_W-1:0] tick_cnt = '0;
   logic [WORD_W-1:0] tx_frame_word = '0;
   logic [POS_W-1:0] tx_step = POS_IDLE;
   logic carrier_q = 1'b0;
   logic [POS_W-1:0] rx_step = POS_START;
   logic [BYTE_W-1:0] rx_data_bits = '0;
   logic [BYTE_W-1:0] rx_inv_bits = '0;
   logic [BYTE_W-1:0] rx_last_byte = '0;

   ir_result_type outputs_due[$];
   int unsigned items_sent = 0;
   int unsigned results_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   logic sender_idles = 1'b1;
   logic receiver_idles = 1'b1;
   logic hold_receiver = 1'b0;

   function automatic logic receive_bit_step(input logic line_low);
      logic accepted;
      accepted = 1'b0;
      if (rx_step == POS_START) begin
         if (line_low) begin
            rx_step = POS_INV_FIRST;
            rx_data_bits = '0;
            rx_inv_bits = '0;
         end
      end else if (rx_step <= POS_INV_LAST) begin
         rx_inv_bits = rx_inv_bits | (BYTE_W'(line_low) << (rx_step - POS_INV_FIRST));
         rx_step = rx_step + 1'b1;
      end else if (rx_step <= POS_DATA_LAST) begin
         rx_data_bits = rx_data_bits | (BYTE_W'(line_low) << (rx_step - POS_INV_LAST - 1'b1));
         rx_step = rx_step + 1'b1;
      end else if (rx_step == POS_STOP) begin
         rx_step = POS_START;
         if (line_low && rx_data_bits == ~rx_inv_bits && rx_data_bits != BYTE_ALL_ONES) begin
            rx_last_byte = rx_data_bits;
            accepted = 1'b1;
         end
      end else begin
         rx_step = POS_START;
      end
      return accepted;
   endfunction

   function automatic void transmit_bit_step();
      if (tx_step < POS_IDLE && tx_frame_word != '0) begin
         if (tx_step == POS_START || tx_step == POS_STOP)
            carrier_q = 1'b1;
         else
            carrier_q = tx_frame_word[tx_step - 1'b1];
         tx_step = tx_step + 1'b1;
      end else if (tx_step >= POS_IDLE) begin
         carrier_q = 1'b0;
      end
   endfunction

   function automatic ir_result_type predict_transceiver(
      input logic action, input logic line_low, input logic [BYTE_W-1:0] value);
      ir_result_type res;
      logic accepted;
      accepted = 1'b0;
      if (action == ACTION_SEND) begin
         tx_frame_word = {value, ~value};
         tx_step = POS_START;
      end else if (tick_cnt == cur_bit_period) begin
         tick_cnt = 8'd1;
         accepted = receive_bit_step(line_low);
         transmit_bit_step();
      end else begin
         tick_cnt = tick_cnt + 1'b1;
      end
      res.carrier_enable = carrier_q;
      res.rx_valid = accepted;
      res.rx_byte = rx_last_byte;
      res.tx_busy = (tx_step < POS_IDLE);
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED)
         $display("mismatch at result %0d: %s", results_seen, msg);
      mismatch_count++;
   endtask

   task automatic check_result(input ir_result_type got);
      ir_result_type want;
      if (outputs_due.size() == 0) begin
         report_mismatch($sformatf("result %h with no item pending", got));
         return;
      end
      want = outputs_due.pop_front();
      if (got.carrier_enable !== want.carrier_enable)
         report_mismatch($sformatf("carrier_enable %b, want %b", got.carrier_enable,
                                   want.carrier_enable));
      if (got.rx_valid !== want.rx_valid)
         report_mismatch($sformatf("rx_valid %b, want %b", got.rx_valid, want.rx_valid));
      if (got.rx_byte !== want.rx_byte)
         report_mismatch($sformatf("rx_byte %h, want %h", got.rx_byte, want.rx_byte));
      if (got.tx_busy !== want.tx_busy)
         report_mismatch($sformatf("tx_busy %b, want %b", got.tx_busy, want.tx_busy));
   endtask

   // called at a clock edge; returns at the edge that takes the item
   task automatic offer_item(input logic action, input logic line_low,
                             input logic [BYTE_W-1:0] value, input logic typed,
                             input ir_result_type want);
      int unsigned gap;
      ir_result_type predicted;
      gap = sender_idles ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_rx_line_low <= line_low;
      req_tx_value <= value;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = predict_transceiver(action, line_low, value);
      outputs_due.push_back(typed ? want : predicted);
      items_sent++;
      if ($urandom_range(0, 39) == 0) sender_idles = !sender_idles;
   endtask

   // one timer tick, now and then preceded by a send request
   task automatic tick_with_sends(input logic line_low);
      if ($urandom_range(0, 15) == 0)
         offer_item(ACTION_SEND, 1'($urandom), 8'($urandom), 1'b0, RES_IDLE);
      offer_item(ACTION_TICK, line_low, 8'($urandom), 1'b0, RES_IDLE);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (outputs_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_bit_period(input logic [BYTE_W-1:0] period);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= period;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_bit_period = period;
   endtask

   // line levels held one bit period each, so every level lands on one step
   task automatic run_frames(input int unsigned budget);
      int unsigned first;
      int unsigned shape_no;
      int unsigned pick;
      int unsigned lead;
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] inv;
      logic stop_mark;
      logic [FRAME_STEPS-1:0] levels;
      first = items_sent;
      shape_no = 0;
      while (items_sent - first < budget) begin
         pick = (shape_no <= SHAPE_NOISE) ? shape_no : $urandom_range(0, 9);
         shape_no++;
         data = 8'($urandom);
         inv = ~data;
         stop_mark = 1'b1;
         case (pick)
            SHAPE_ALL_ONES: begin
               data = BYTE_ALL_ONES;
               inv = ~BYTE_ALL_ONES;
            end
            SHAPE_BAD_CHECK: inv = inv ^ (8'd1 << $urandom_range(0, 7));
            SHAPE_NO_STOP: stop_mark = 1'b0;
            default: ;
         endcase
         levels = {stop_mark, data, inv, 1'b1};
         if (pick == SHAPE_NOISE) levels = FRAME_STEPS'($urandom);
         lead = $urandom_range(1, 3);
         repeat (lead * cur_bit_period) tick_with_sends(1'b0);
         for (int s = 0; s < FRAME_STEPS; s++)
            repeat (cur_bit_period) tick_with_sends(levels[s]);
      end
   endtask

   // also leaves the count above 1 so a later period of 1 has to wrap
   task automatic run_line_noise(input int unsigned min_ticks);
      int unsigned n;
      n = 0;
      while (n < min_ticks || tick_cnt < 8'd2) begin
         tick_with_sends(1'($urandom));
         n++;
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int unsigned hold;
      ir_result_type got;
      wait (reset == 1'b0);
      forever begin
         if (hold_receiver) begin
            hold = LONG_HOLD;
            hold_receiver = 1'b0;
         end else begin
            hold = receiver_idles ? $urandom_range(0, 5) : 0;
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         got = '{rsp_carrier_enable, rsp_rx_valid, rsp_rx_byte, rsp_tx_busy};
         check_result(got);
         results_seen++;
         if ($urandom_range(0, 39) == 0) receiver_idles = !receiver_idles;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DRILL_LEN; i++) begin
         if (DRILL_ROWS[i].kind == ROW_PERIOD)
            write_bit_period(DRILL_ROWS[i].value);
         else
            offer_item(DRILL_ROWS[i].action, DRILL_ROWS[i].line_low, DRILL_ROWS[i].value,
                       DRILL_ROWS[i].typed, DRILL_ROWS[i].want);
      end
      write_bit_period(8'd1);
      run_frames(45);
      hold_receiver = 1'b1;
      run_frames(45);
      write_bit_period(8'd3);
      run_frames(35);
      wait_drained();
      run_frames(35);
      write_bit_period(8'd255);
      run_line_noise(256);
      // period below the count: it wraps through 255 before the next step
      write_bit_period(8'd1);
      run_frames(300);
      wait_drained();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
